### rtl/h264_coeff_quantizer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the coefficient quantizer
// Assertions are sampled on clk; the checked form is left out of synthesis.
// ----------------------------------------------------------------------------
`ifndef H264_COEFF_QUANTIZER_CORE_ASSERT_SVH
`define H264_COEFF_QUANTIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// check on clk, quiet while rst_n is low
`define HCQ_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// check on clk, also while rst_n is low
`define HCQ_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`else

`define HCQ_ASSERT(label, prop)
`define HCQ_ASSERT_ALWAYS(label, prop)

`endif

`endif

### rtl/hcq_pkg.sv
// ----------------------------------------------------------------------------
// hcq_pkg
// Types, constants and tables shared by the coefficient quantizer pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hcq_pkg;

    localparam int COEFF_W   = 19;
    localparam int OUT_W     = 32;
    localparam int QP_W      = 6;
    localparam int MODE_W    = 2;
    localparam int POS_W     = 2;
    localparam int OFFSET_W  = 16;
    localparam int OFB_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int MF_W      = 14;
    localparam int V_W       = 5;
    localparam int MAX_PER   = 10;
    localparam int PER_W     = 4;
    localparam int REM_W     = 3;
    localparam int F_W       = V_W + MAX_PER;
    localparam int A_W       = COEFF_W + 1;
    localparam int B_W       = F_W;
    localparam int PROD_W    = A_W + B_W + 1;

    // qp / 6 as (qp * 43) >> 8, exact for qp below 64
    localparam int PER_RECIP    = 43;
    localparam int PER_RECIP_SH = 8;
    localparam int PER_PROD_W   = QP_W + 6;

    localparam int QBITS_BASE_DEF = 15;

    localparam logic                USE_INTRA_RST    = 1'b1;
    localparam logic [OFFSET_W-1:0] INTRA_OFFSET_RST = 16'd682;
    localparam logic [OFFSET_W-1:0] INTER_OFFSET_RST = 16'd342;
    localparam logic [OFB_W-1:0]    OFB_RST          = 4'd11;

    typedef enum logic {
        KIND_FWD = 1'b0,
        KIND_INV = 1'b1
    } kind_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_4X4 = 2'd0,
        MODE_AC  = 2'd1,
        MODE_DC4 = 2'd2,
        MODE_DC2 = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USE_INTRA    = 2'd0,
        CFG_INTRA_OFFSET = 2'd1,
        CFG_INTER_OFFSET = 2'd2,
        CFG_OFB          = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CLS_EVEN  = 2'd0,
        CLS_ODD   = 2'd1,
        CLS_MIXED = 2'd2
    } cls_t;

    typedef struct packed {
        logic       inverse;
        logic       dc;
        logic       neg;
        logic       zero;
        logic [1:0] dc_shift;
    } hcq_ctl_t;

    function automatic int hcq_off_w(input int qbits_base);
        return OFFSET_W + qbits_base + MAX_PER;
    endfunction

    // room for the doubled offset plus the product, signed
    function automatic int hcq_sum_w(input int qbits_base);
        int w;
        w = hcq_off_w(qbits_base) + 1;
        return ((w > PROD_W) ? w : PROD_W) + 2;
    endfunction

    function automatic int hcq_shamt_w(input int qbits_base);
        return $clog2(qbits_base + MAX_PER + 2);
    endfunction

    function automatic int hcq_sh_w(input int qbits_base);
        return $clog2(qbits_base + MAX_PER + 1) + 1;
    endfunction

    function automatic logic [MF_W-1:0] hcq_quant(input logic [REM_W-1:0] rem,
                                                  input cls_t cls);
        logic [MF_W-1:0] e0;
        logic [MF_W-1:0] e1;
        logic [MF_W-1:0] e2;
        case (rem)
            3'd0: begin e0 = 14'd13107; e1 = 14'd5243; e2 = 14'd8066; end
            3'd1: begin e0 = 14'd11916; e1 = 14'd4660; e2 = 14'd7490; end
            3'd2: begin e0 = 14'd10082; e1 = 14'd4194; e2 = 14'd6554; end
            3'd3: begin e0 = 14'd9362;  e1 = 14'd3647; e2 = 14'd5825; end
            3'd4: begin e0 = 14'd8192;  e1 = 14'd3355; e2 = 14'd5243; end
            3'd5: begin e0 = 14'd7282;  e1 = 14'd2893; e2 = 14'd4559; end
            default: begin e0 = '0; e1 = '0; e2 = '0; end
        endcase
        case (cls)
            CLS_EVEN: return e0;
            CLS_ODD:  return e1;
            default:  return e2;
        endcase
    endfunction

    function automatic logic [V_W-1:0] hcq_dequant(input logic [REM_W-1:0] rem,
                                                   input cls_t cls);
        logic [V_W-1:0] e0;
        logic [V_W-1:0] e1;
        logic [V_W-1:0] e2;
        case (rem)
            3'd0: begin e0 = 5'd10; e1 = 5'd16; e2 = 5'd13; end
            3'd1: begin e0 = 5'd11; e1 = 5'd18; e2 = 5'd14; end
            3'd2: begin e0 = 5'd13; e1 = 5'd20; e2 = 5'd16; end
            3'd3: begin e0 = 5'd14; e1 = 5'd23; e2 = 5'd18; end
            3'd4: begin e0 = 5'd16; e1 = 5'd25; e2 = 5'd20; end
            3'd5: begin e0 = 5'd18; e1 = 5'd29; e2 = 5'd23; end
            default: begin e0 = '0; e1 = '0; e2 = '0; end
        endcase
        case (cls)
            CLS_EVEN: return e0;
            CLS_ODD:  return e1;
            default:  return e2;
        endcase
    endfunction

endpackage

`default_nettype wire

### rtl/hcq_decode.sv
// ----------------------------------------------------------------------------
// hcq_decode
// Stage 1: split qp, look up scale factors, pick operands, offset and shifts.
// ----------------------------------------------------------------------------
`default_nettype none
`include "h264_coeff_quantizer_core_assert.svh"

module hcq_decode #(
    parameter int QBITS_BASE = hcq_pkg::QBITS_BASE_DEF
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          en,
    input  wire logic                                          valid_in,
    input  wire logic                                          kind,
    input  wire logic [hcq_pkg::MODE_W-1:0]                    block_mode,
    input  wire logic [hcq_pkg::POS_W-1:0]                     col,
    input  wire logic [hcq_pkg::POS_W-1:0]                     row,
    input  wire logic [hcq_pkg::QP_W-1:0]                      qp,
    input  wire logic signed [hcq_pkg::COEFF_W-1:0]            coeff_in,
    input  wire logic                                          use_intra_offset,
    input  wire logic [hcq_pkg::OFFSET_W-1:0]                  intra_offset,
    input  wire logic [hcq_pkg::OFFSET_W-1:0]                  inter_offset,
    input  wire logic [hcq_pkg::OFB_W-1:0]                     offset_fraction_bits,
    output logic                                               valid_out,
    output hcq_pkg::hcq_ctl_t                                  ctl,
    output logic signed [hcq_pkg::A_W-1:0]                     op_a,
    output logic [hcq_pkg::B_W-1:0]                            op_b,
    output logic [hcq_pkg::OFFSET_W-1:0]                       off,
    output logic signed [hcq_pkg::hcq_sh_w(QBITS_BASE)-1:0]    sh,
    output logic [hcq_pkg::hcq_shamt_w(QBITS_BASE)-1:0]        shamt
);
    import hcq_pkg::*;

    localparam int SH_W    = hcq_sh_w(QBITS_BASE);
    localparam int SHAMT_W = hcq_shamt_w(QBITS_BASE);

    logic [PER_PROD_W-1:0] per_prod;
    logic [PER_W-1:0]      per;
    logic [QP_W-1:0]       rem_full;
    logic [REM_W-1:0]      rem;
    logic                  dc;
    logic                  inverse;
    cls_t                  cls;
    logic [MF_W-1:0]       mf;
    logic [V_W-1:0]        vf;
    logic [F_W-1:0]        fscale;
    logic signed [A_W-1:0] x_ext;
    logic signed [A_W-1:0] x_mag;

    logic                     valid_reg;
    hcq_ctl_t                 ctl_reg,   ctl_next;
    logic signed [A_W-1:0]    op_a_reg,  op_a_next;
    logic [B_W-1:0]           op_b_reg,  op_b_next;
    logic [OFFSET_W-1:0]      off_reg,   off_next;
    logic signed [SH_W-1:0]   sh_reg,    sh_next;
    logic [SHAMT_W-1:0]       shamt_reg, shamt_next;

    always_comb
    begin
        per_prod = PER_PROD_W'(qp) * PER_PROD_W'(PER_RECIP);
        per      = per_prod[PER_RECIP_SH +: PER_W];
        rem_full = qp - QP_W'(per) * QP_W'(6);
        rem      = rem_full[REM_W-1:0];
        dc       = (block_mode == MODE_DC4) || (block_mode == MODE_DC2);
        inverse  = (kind == KIND_INV);

        // DC modes always take the even-even entry
        if (dc || (!row[0] && !col[0]))
            cls = CLS_EVEN;
        else if (row[0] && col[0])
            cls = CLS_ODD;
        else
            cls = CLS_MIXED;

        mf     = hcq_quant(rem, cls);
        vf     = hcq_dequant(rem, cls);
        fscale = F_W'(vf) << per;

        x_ext = A_W'(coeff_in);
        x_mag = coeff_in[COEFF_W-1] ? -x_ext : x_ext;

        ctl_next.inverse = inverse;
        ctl_next.dc      = dc;
        ctl_next.neg     = !inverse && coeff_in[COEFF_W-1];
        ctl_next.zero    = (block_mode == MODE_AC) && (row == '0) && (col == '0);
        if (inverse && (block_mode == MODE_DC4))
            ctl_next.dc_shift = 2'd2;
        else if (inverse && (block_mode == MODE_DC2))
            ctl_next.dc_shift = 2'd1;
        else
            ctl_next.dc_shift = 2'd0;

        op_a_next = inverse ? x_ext : x_mag;
        op_b_next = inverse ? fscale : B_W'(mf);
        off_next  = use_intra_offset ? intra_offset : inter_offset;
        sh_next   = SH_W'(QBITS_BASE + int'(per) - int'(offset_fraction_bits));
        shamt_next = inverse ? SHAMT_W'(ctl_next.dc_shift)
                             : SHAMT_W'(QBITS_BASE + int'(per) + int'(dc));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg   <= ctl_next;
            op_a_reg  <= op_a_next;
            op_b_reg  <= op_b_next;
            off_reg   <= off_next;
            sh_reg    <= sh_next;
            shamt_reg <= shamt_next;
        end
    end

    assign valid_out = valid_reg;
    assign ctl       = ctl_reg;
    assign op_a      = op_a_reg;
    assign op_b      = op_b_reg;
    assign off       = off_reg;
    assign sh        = sh_reg;
    assign shamt     = shamt_reg;

    `HCQ_ASSERT(a_inv_shift_small,
        (en && valid_in && kind == KIND_INV) |=> (shamt_reg <= SHAMT_W'(2)))

endmodule

`default_nettype wire

### rtl/hcq_mul.sv
// ----------------------------------------------------------------------------
// hcq_mul
// Stage 2: scale multiply and rounding offset alignment.
// ----------------------------------------------------------------------------
`default_nettype none

module hcq_mul #(
    parameter int QBITS_BASE = hcq_pkg::QBITS_BASE_DEF
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          en,
    input  wire logic                                          valid_in,
    input  wire hcq_pkg::hcq_ctl_t                             ctl_in,
    input  wire logic signed [hcq_pkg::A_W-1:0]                op_a,
    input  wire logic [hcq_pkg::B_W-1:0]                       op_b,
    input  wire logic [hcq_pkg::OFFSET_W-1:0]                  off,
    input  wire logic signed [hcq_pkg::hcq_sh_w(QBITS_BASE)-1:0] sh,
    input  wire logic [hcq_pkg::hcq_shamt_w(QBITS_BASE)-1:0]   shamt_in,
    output logic                                               valid_out,
    output hcq_pkg::hcq_ctl_t                                  ctl_out,
    output logic signed [hcq_pkg::PROD_W-1:0]                  prod,
    output logic [hcq_pkg::hcq_off_w(QBITS_BASE)-1:0]          off_scaled,
    output logic [hcq_pkg::hcq_shamt_w(QBITS_BASE)-1:0]        shamt_out
);
    import hcq_pkg::*;

    localparam int SH_W    = hcq_sh_w(QBITS_BASE);
    localparam int SHAMT_W = hcq_shamt_w(QBITS_BASE);
    localparam int OFF_W   = hcq_off_w(QBITS_BASE);

    logic [SH_W-1:0] sh_mag;

    logic                     valid_reg;
    hcq_ctl_t                 ctl_reg;
    logic signed [PROD_W-1:0] prod_reg,  prod_next;
    logic [OFF_W-1:0]         offs_reg,  offs_next;
    logic [SHAMT_W-1:0]       shamt_reg;

    always_comb
    begin
        prod_next = op_a * $signed({1'b0, op_b});
        // a negative scale moves the offset right
        sh_mag    = sh[SH_W-1] ? SH_W'(-sh) : SH_W'(sh);
        offs_next = sh[SH_W-1] ? (OFF_W'(off) >> sh_mag) : (OFF_W'(off) << sh_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg   <= ctl_in;
            prod_reg  <= prod_next;
            offs_reg  <= offs_next;
            shamt_reg <= shamt_in;
        end
    end

    assign valid_out  = valid_reg;
    assign ctl_out    = ctl_reg;
    assign prod       = prod_reg;
    assign off_scaled = offs_reg;
    assign shamt_out  = shamt_reg;

endmodule

`default_nettype wire

### rtl/hcq_round.sv
// ----------------------------------------------------------------------------
// hcq_round
// Stages 3 and 4: add the rounding term, then shift down.
// ----------------------------------------------------------------------------
`default_nettype none

module hcq_round #(
    parameter int QBITS_BASE = hcq_pkg::QBITS_BASE_DEF
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          en,
    input  wire logic                                          valid_in,
    input  wire hcq_pkg::hcq_ctl_t                             ctl_in,
    input  wire logic signed [hcq_pkg::PROD_W-1:0]             prod,
    input  wire logic [hcq_pkg::hcq_off_w(QBITS_BASE)-1:0]     off_scaled,
    input  wire logic [hcq_pkg::hcq_shamt_w(QBITS_BASE)-1:0]   shamt,
    output logic                                               valid_out,
    output hcq_pkg::hcq_ctl_t                                  ctl_out,
    output logic signed [hcq_pkg::hcq_sum_w(QBITS_BASE)-1:0]   value
);
    import hcq_pkg::*;

    localparam int SHAMT_W = hcq_shamt_w(QBITS_BASE);
    localparam int SUM_W   = hcq_sum_w(QBITS_BASE);

    logic signed [SUM_W-1:0] addend;

    logic                    v3_reg;
    hcq_ctl_t                ctl3_reg;
    logic [SHAMT_W-1:0]      shamt3_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    logic                    v4_reg;
    hcq_ctl_t                ctl4_reg;
    logic signed [SUM_W-1:0] shf_reg, shf_next;

    always_comb
    begin
        // inverse DC rounds half up: the half step equals the shift code
        if (ctl_in.inverse)
            addend = SUM_W'(ctl_in.dc_shift);
        else if (ctl_in.dc)
            addend = SUM_W'({off_scaled, 1'b0});
        else
            addend = SUM_W'(off_scaled);
        sum_next = SUM_W'(prod) + addend;
        // forward sums are never negative, so one arithmetic shift serves both
        shf_next = sum_reg >>> shamt3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= valid_in;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl3_reg   <= ctl_in;
            shamt3_reg <= shamt;
            sum_reg    <= sum_next;
            ctl4_reg   <= ctl3_reg;
            shf_reg    <= shf_next;
        end
    end

    assign valid_out = v4_reg;
    assign ctl_out   = ctl4_reg;
    assign value     = shf_reg;

endmodule

`default_nettype wire

### rtl/hcq_sat.sv
// ----------------------------------------------------------------------------
// hcq_sat
// Stage 5: restore the sign, clamp to 32 bits (or force zero at the AC DC position), hold the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "h264_coeff_quantizer_core_assert.svh"

module hcq_sat #(
    parameter int QBITS_BASE = hcq_pkg::QBITS_BASE_DEF
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          en,
    input  wire logic                                          valid_in,
    input  wire hcq_pkg::hcq_ctl_t                             ctl,
    input  wire logic signed [hcq_pkg::hcq_sum_w(QBITS_BASE)-1:0] value,
    output logic                                               valid_out,
    output logic [hcq_pkg::OUT_W-1:0]                          coeff_out
);
    import hcq_pkg::*;

    localparam int SUM_W = hcq_sum_w(QBITS_BASE);
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [SUM_W-1:0] sval;

    logic               valid_reg;
    logic [OUT_W-1:0]   coeff_out_reg, coeff_out_next;

    always_comb
    begin
        sval = ctl.neg ? -value : value;
        if (ctl.zero)
            coeff_out_next = '0;
        else if (sval > SAT_MAX)
            coeff_out_next = SAT_MAX[OUT_W-1:0];
        else if (sval < SAT_MIN)
            coeff_out_next = SAT_MIN[OUT_W-1:0];
        else
            coeff_out_next = sval[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            coeff_out_reg <= coeff_out_next;
    end

    assign valid_out = valid_reg;
    assign coeff_out = coeff_out_reg;

    `HCQ_ASSERT(a_ac_dc_zero,
        (en && valid_in && ctl.zero) |=> (coeff_out_reg == '0))
    `HCQ_ASSERT(a_fwd_sign_kept,
        (en && valid_in && !ctl.inverse && !ctl.neg) |=> !coeff_out_reg[OUT_W-1])

endmodule

`default_nettype wire

### rtl/h264_coeff_quantizer_core.sv
// ----------------------------------------------------------------------------
// h264_coeff_quantizer_core
// Per-coefficient 4x4 quantizer / dequantizer, five-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   direction  tdata / tuser
//  s_axis    in         tdata: col, row, qp, coeff_in; tuser: kind, block_mode
//  m_axis    out        tdata: coeff_out
//  cfg       in         cfg_wr_en, cfg_index, cfg_data (write only)
//
//  One coefficient per cycle unless the output stalls.
//  Stages: decode and table lookup, multiply, round add, shift, saturate.
//  All stages advance together; a stalled output freezes the whole pipe
//  and drops s_axis_tready until the held result is taken.
//  Reset clears the valid bits and loads the default offsets.
// ----------------------------------------------------------------------------
`default_nettype none
`include "h264_coeff_quantizer_core_assert.svh"

module h264_coeff_quantizer_core #(
    parameter int QBITS_BASE = hcq_pkg::QBITS_BASE_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [1:0] col, [3:2] row, [9:4] qp, [28:10] coeff_in, [31:29] zero
    input  wire logic [31:0]                       s_axis_tdata,
    // [0] kind, [2:1] block_mode
    input  wire logic [2:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [31:0] coeff_out
    output logic [hcq_pkg::OUT_W-1:0]              m_axis_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [hcq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hcq_pkg::OFFSET_W-1:0]      cfg_data
);
    import hcq_pkg::*;

    localparam int SH_W    = hcq_sh_w(QBITS_BASE);
    localparam int SHAMT_W = hcq_shamt_w(QBITS_BASE);
    localparam int OFF_W   = hcq_off_w(QBITS_BASE);
    localparam int SUM_W   = hcq_sum_w(QBITS_BASE);

    logic                use_intra_reg;
    logic [OFFSET_W-1:0] intra_off_reg;
    logic [OFFSET_W-1:0] inter_off_reg;
    logic [OFB_W-1:0]    ofb_reg;

    logic adv;

    logic                    v1;
    hcq_ctl_t                ctl1;
    logic signed [A_W-1:0]   op_a1;
    logic [B_W-1:0]          op_b1;
    logic [OFFSET_W-1:0]     off1;
    logic signed [SH_W-1:0]  sh1;
    logic [SHAMT_W-1:0]      shamt1;

    logic                     v2;
    hcq_ctl_t                 ctl2;
    logic signed [PROD_W-1:0] prod2;
    logic [OFF_W-1:0]         offs2;
    logic [SHAMT_W-1:0]       shamt2;

    logic                    v4;
    hcq_ctl_t                ctl4;
    logic signed [SUM_W-1:0] val4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_intra_reg <= USE_INTRA_RST;
            intra_off_reg <= INTRA_OFFSET_RST;
            inter_off_reg <= INTER_OFFSET_RST;
            ofb_reg       <= OFB_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_USE_INTRA:    use_intra_reg <= cfg_data[0];
                CFG_INTRA_OFFSET: intra_off_reg <= cfg_data;
                CFG_INTER_OFFSET: inter_off_reg <= cfg_data;
                CFG_OFB:          ofb_reg       <= cfg_data[OFB_W-1:0];
                default:          ofb_reg       <= ofb_reg;
            endcase
        end
    end

    // advance everything unless a held result is waiting
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    hcq_decode #(.QBITS_BASE(QBITS_BASE)) u_decode (
        .clk                  (clk),
        .rst_n                (rst_n),
        .en                   (adv),
        .valid_in             (s_axis_tvalid),
        .kind                 (s_axis_tuser[0]),
        .block_mode           (s_axis_tuser[2:1]),
        .col                  (s_axis_tdata[1:0]),
        .row                  (s_axis_tdata[3:2]),
        .qp                   (s_axis_tdata[9:4]),
        .coeff_in             (s_axis_tdata[28:10]),
        .use_intra_offset     (use_intra_reg),
        .intra_offset         (intra_off_reg),
        .inter_offset         (inter_off_reg),
        .offset_fraction_bits (ofb_reg),
        .valid_out            (v1),
        .ctl                  (ctl1),
        .op_a                 (op_a1),
        .op_b                 (op_b1),
        .off                  (off1),
        .sh                   (sh1),
        .shamt                (shamt1)
    );

    hcq_mul #(.QBITS_BASE(QBITS_BASE)) u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .valid_in   (v1),
        .ctl_in     (ctl1),
        .op_a       (op_a1),
        .op_b       (op_b1),
        .off        (off1),
        .sh         (sh1),
        .shamt_in   (shamt1),
        .valid_out  (v2),
        .ctl_out    (ctl2),
        .prod       (prod2),
        .off_scaled (offs2),
        .shamt_out  (shamt2)
    );

    hcq_round #(.QBITS_BASE(QBITS_BASE)) u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .valid_in   (v2),
        .ctl_in     (ctl2),
        .prod       (prod2),
        .off_scaled (offs2),
        .shamt      (shamt2),
        .valid_out  (v4),
        .ctl_out    (ctl4),
        .value      (val4)
    );

    hcq_sat #(.QBITS_BASE(QBITS_BASE)) u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (v4),
        .ctl       (ctl4),
        .value     (val4),
        .valid_out (m_axis_tvalid),
        .coeff_out (m_axis_tdata)
    );

    `HCQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_axis_tvalid)
    `HCQ_ASSERT(a_pipe_frozen, !adv |=> ($stable(v1) && $stable(v2) && $stable(v4)))

endmodule

`default_nettype wire
